// File: rtl/udff_pkg.sv
// Shared types, constants and register codes for the unsigned decimal field formatter.
`timescale 1ns / 1ps

package udff_pkg;

  localparam int MAX_WIDTH_DEF  = 63;
  localparam int VALUE_BITS_DEF = 64;

  // register file
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 3;

  // largest digit count over the whole VALUE_BITS range (64-bit values)
  localparam int MAX_DIGITS = 20;
  localparam int NDIG_W     = $clog2(MAX_DIGITS + 1);

  // front-to-back queue
  localparam int QDEPTH = 2;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIELD_WIDTH     = 3'd0,
    REG_ZERO_PAD_ENABLE = 3'd1,
    REG_ZERO_PAD_WIDTH  = 3'd2,
    REG_PRECISION_GIVEN = 3'd3,
    REG_PRECISION       = 3'd4,
    REG_LJ_WIDTH        = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [CFG_W-1:0] field_width;
    logic             zero_pad_enable;
    logic [CFG_W-1:0] zero_pad_width;
    logic             precision_given;
    logic [CFG_W-1:0] precision;
    logic [CFG_W-1:0] left_justify_width;
  } cfg_t;

  // one converted value waiting for emission
  typedef struct packed {
    logic [MAX_DIGITS-1:0][3:0] digits;
    logic [NDIG_W-1:0]          ndig;
    logic                       is_zero;
  } q_entry_t;

endpackage

// File: rtl/udff_front.sv
// Front part: accepts a value and converts it to BCD by shift-and-add-3.
`timescale 1ns / 1ps

module udff_front import udff_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  q_full,
  output logic                  q_wr,
  output q_entry_t              q_data
);

  // digits of 2^n - 1 = floor(n * log10 2) + 1
  localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int CNT_W  = $clog2(VALUE_BITS);

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_DONE} state_t;

  state_t                  state;
  logic [VALUE_BITS-1:0]   shreg;
  logic [DIGITS*4-1:0]     bcd;
  logic [DIGITS*4-1:0]     bcd_adj;
  logic [DIGITS*4-1:0]     bcd_next;
  logic [CNT_W-1:0]        cnt;
  logic [NDIG_W-1:0]       ndig;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
    bcd_next = {bcd_adj[DIGITS*4-2:0], shreg[VALUE_BITS-1]};
  end

  // highest nonzero digit, one digit minimum
  always_comb begin
    ndig = NDIG_W'(1);
    for (int i = 1; i < DIGITS; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) ndig = NDIG_W'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (push) begin
            shreg <= value;
            bcd   <= '0;
            cnt   <= '0;
            state <= S_CONV;
          end
        end
        S_CONV: begin
          bcd   <= bcd_next;
          shreg <= shreg << 1;
          cnt   <= cnt + 1'b1;
          if (cnt == CNT_W'(VALUE_BITS - 1)) state <= S_DONE;
        end
        S_DONE: begin
          if (!q_full) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign full           = (state != S_IDLE);
  assign q_wr           = (state == S_DONE) && !q_full;
  assign q_data.digits  = (MAX_DIGITS*4)'(bcd);
  assign q_data.ndig    = ndig;
  assign q_data.is_zero = (bcd == '0);

endmodule

// File: rtl/udff_queue.sv
// Short queue of converted values between the front and back parts.
`timescale 1ns / 1ps

module udff_queue import udff_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr,
  input  q_entry_t wdata,
  output logic     full,
  input  logic     rd,
  output q_entry_t rdata,
  output logic     empty
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  q_entry_t           mem [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (wr) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= ptr_inc(wr_ptr);
      if (rd) rd_ptr <= ptr_inc(rd_ptr);
      if (wr && !rd)      count <= count + 1'b1;
      else if (rd && !wr) count <= count - 1'b1;
    end
  end

  assign rdata = mem[rd_ptr];
  assign full  = (count == CNT_W'(QDEPTH));
  assign empty = (count == '0);

endmodule

// File: rtl/udff_back.sv
// Back part: lays out padding, digits and fill, and emits one character per word.
`timescale 1ns / 1ps

module udff_back import udff_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       q_empty,
  output logic       q_rd,
  input  q_entry_t   q_data,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] character,
  output logic       is_empty,
  output logic       last_char
);

  localparam int POS_W  = $clog2(MAX_WIDTH + 1);
  localparam int CALC_W = ((POS_W > CFG_W) ? POS_W : CFG_W) + 1;
  localparam int DIDX_W = $clog2(MAX_DIGITS);
  localparam logic [CALC_W-1:0] MAXW = CALC_W'(MAX_WIDTH);

  typedef enum logic {S_IDLE, S_EMIT} state_t;

  function automatic logic [CALC_W-1:0] umax(input logic [CALC_W-1:0] a,
                                             input logic [CALC_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [CALC_W-1:0] sat(input logic [CFG_W-1:0] w);
    logic [CALC_W-1:0] x;
    x = CALC_W'(w);
    return (x > MAXW) ? MAXW : x;
  endfunction

  // layout of the next queued value
  logic [CALC_W-1:0] c_prec, c_width, c_lp, c_ndig, c_n1, c_n2, c_body, c_total;
  logic              c_sup;
  logic [7:0]        c_pad;

  always_comb begin
    c_ndig  = CALC_W'(q_data.ndig);
    c_prec  = sat(cfg.precision);
    c_width = umax(sat(cfg.zero_pad_enable ? cfg.zero_pad_width : cfg.field_width), c_prec);
    c_lp    = umax(c_ndig, c_prec);
    c_n1    = (c_width > c_lp)   ? c_width - c_lp   : '0;
    c_n2    = (c_width > c_ndig) ? c_width - c_ndig : '0;
    c_sup   = q_data.is_zero && cfg.precision_given && (cfg.precision == '0);
    // suppressed zero: a single space stands in for the digit when width > 0
    c_body  = c_sup ? c_width : c_n2 + c_ndig;
    c_total = umax(c_body, sat(cfg.left_justify_width));
    c_pad   = CHAR_SPACE;
    if (cfg.zero_pad_enable &&
        !(cfg.precision_given && (cfg.zero_pad_width > cfg.precision))) c_pad = CHAR_ZERO;
  end

  state_t                     state;
  logic [POS_W-1:0]           n1, n2, body, total, pos;
  logic [7:0]                 pad;
  logic                       sup;
  logic [MAX_DIGITS-1:0][3:0] digits;
  logic                       ovalid;
  logic [7:0]                 ochar;
  logic                       olast;
  logic                       oempty;

  logic [CALC_W-1:0] didx;
  logic [7:0]        ch;
  logic              last;
  logic              out_free;

  always_comb begin
    didx = CALC_W'(body) - CALC_W'(pos) - 1'b1;
    if (pos < n1)        ch = pad;
    else if (pos < n2)   ch = CHAR_ZERO;
    else if (pos < body) ch = sup ? CHAR_SPACE : (CHAR_ZERO | {4'h0, digits[didx[DIDX_W-1:0]]});
    else                 ch = CHAR_SPACE;
    last = (total == '0) || (POS_W'(pos + 1'b1) == total);
  end

  assign out_free = !ovalid || pop;
  assign q_rd     = (state == S_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (pop) ovalid <= 1'b0;
          if (!q_empty) begin
            n1     <= POS_W'(c_n1);
            n2     <= POS_W'(c_n2);
            body   <= POS_W'(c_body);
            total  <= POS_W'(c_total);
            pad    <= c_pad;
            sup    <= c_sup;
            digits <= q_data.digits;
            pos    <= '0;
            state  <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            ovalid <= 1'b1;
            ochar  <= (total == '0) ? CHAR_NUL : ch;
            oempty <= (total == '0);
            olast  <= last;
            pos    <= pos + 1'b1;
            if (last) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign empty     = !ovalid;
  assign character = ochar;
  assign is_empty  = oempty;
  assign last_char = olast;

endmodule

// File: rtl/unsigned_decimal_field_formatter.sv
// Top level of the unsigned decimal field formatter: registers, front, queue and back.
`timescale 1ns / 1ps

// Formats an unsigned value as printf %u text, one ASCII character per result word.
// Input channel: a value is taken at a clock edge with push high and full low.
// Result channel: while empty is low the oldest character sits on character,
// is_empty and last_char; it is taken at an edge with pop high. last_char marks
// the final character of a value; a conversion that yields no text gives one
// word with character 0 and is_empty set.
// Configuration: cfg_we writes cfg_data into register cfg_index (field width,
// zero-pad enable, zero-pad width, precision given, precision, left-justify
// width); indexes past the list are dropped. Write only while the block is idle.
// Timing: the front runs one shift-and-add-3 step per value bit, then queues the
// BCD word; full stays high from the value being taken until the word is queued.
// The back lays out a value in S_IDLE, then, while the receiver keeps up, emits
// one character per cycle (at most MAX_WIDTH characters). A two-deep queue lets
// the front convert the next value while the back emits.
// Reset (synchronous, rst high) clears the configuration to 0 and empties the block.
// A stalled receiver holds the current word; the back then stops, and the front
// stalls once the queue is full.
module unsigned_decimal_field_formatter import udff_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  empty,
  input  logic                  pop,
  output logic [7:0]            character,
  output logic                  is_empty,
  output logic                  last_char,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  cfg_t     cfg;
  logic     q_wr, q_rd, q_full, q_empty;
  q_entry_t q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_FIELD_WIDTH:     cfg.field_width        <= cfg_data;
        REG_ZERO_PAD_ENABLE: cfg.zero_pad_enable    <= cfg_data[0];
        REG_ZERO_PAD_WIDTH:  cfg.zero_pad_width     <= cfg_data;
        REG_PRECISION_GIVEN: cfg.precision_given    <= cfg_data[0];
        REG_PRECISION:       cfg.precision          <= cfg_data;
        REG_LJ_WIDTH:        cfg.left_justify_width <= cfg_data;
        default: ;
      endcase
    end
  end

  udff_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .value  (value),
    .q_full (q_full),
    .q_wr   (q_wr),
    .q_data (q_wdata)
  );

  udff_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  udff_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_rd      (q_rd),
    .q_data    (q_rdata),
    .empty     (empty),
    .pop       (pop),
    .character (character),
    .is_empty  (is_empty),
    .last_char (last_char)
  );

endmodule

// File: rtl/udff_checker.sv
// Port-level assertions for the unsigned decimal field formatter, bound to the top level.
`timescale 1ns / 1ps

module udff_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [7:0] character,
  input logic       is_empty,
  input logic       last_char
);

  // nothing to pop right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result word present after reset");

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
      (!empty && !pop) |=> (!empty && $stable(character) && $stable(last_char)
                            && $stable(is_empty)))
    else $error("stalled result word changed");

  // empty conversion is a single NUL word that closes the run
  a_empty_word: assert property (@(posedge clk) disable iff (rst)
      (!empty && is_empty) |-> (last_char && character == 8'h00))
    else $error("empty-conversion word malformed");

  // ordinary words carry a digit or a space
  a_char_set: assert property (@(posedge clk) disable iff (rst)
      (!empty && !is_empty) |-> (character == 8'h20 ||
                                 (character >= 8'h30 && character <= 8'h39)))
    else $error("character outside digits and space");

endmodule

bind unsigned_decimal_field_formatter udff_checker u_udff_checker (.*);
